/* src/priority_thread_scheduler_macros.svh */
// Assertion macros for the priority thread scheduler.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_THREAD_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS

`define PTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`else

`define PTS_ASSERT_IMPL(label, clk, rst, ante, cons)

`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/pts_pkg.sv */
// Shared types and constants of the priority thread scheduler.
// No dependencies; used by pts_best, pts_seq and the top level.
`default_nettype none

package pts_pkg;

   localparam int QUANT_W  = 4;
   localparam int STATUS_W = 2;

   localparam logic [1:0] FN_CREATE = 2'd0;
   localparam logic [1:0] FN_TICK   = 2'd1;
   localparam logic [1:0] FN_SCHED  = 2'd2;
   localparam logic [1:0] FN_SET    = 2'd3;

   localparam logic [STATUS_W-1:0] THR_READY   = 2'd0;
   localparam logic [STATUS_W-1:0] THR_RUNNING = 2'd1;

   localparam logic [2:0]         DISPATCH_LVL  = 3'd2;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 4'd3;

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

endpackage

`default_nettype wire

/* src/pts_ifs.sv */
// Handshake channels of the scheduler: command, result and configuration words.
// No dependencies.
`default_nettype none

interface pts_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [4:0] priority_req;
   logic [3:0] thread_id;
   logic [1:0] new_state;
   logic [2:0] irql_level;

   modport source (output valid, func, priority_req, thread_id, new_state, irql_level,
                   input ready);
   modport sink (input valid, func, priority_req, thread_id, new_state, irql_level,
                 output ready);
endinterface

interface pts_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] running_id;
   logic       switched;
   logic       reschedule_pending;
   logic       preempt_immediate;
   logic       table_full_error;
   logic [3:0] threads_used;

   modport source (output valid, running_id, switched, reschedule_pending,
                   preempt_immediate, table_full_error, threads_used, input ready);
   modport sink (input valid, running_id, switched, reschedule_pending,
                 preempt_immediate, table_full_error, threads_used, output ready);
endinterface

interface pts_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] quantum_length;

   modport source (output valid, quantum_length, input ready);
   modport sink (input valid, quantum_length, output ready);
endinterface

`default_nettype wire

/* src/pts_table.sv */
// Thread table memory: one write port and one registered read port.
// No dependencies.
`default_nettype none

module pts_table #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 11
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/pts_best.sv */
// Shared compare unit that keeps the first ready entry of highest priority during a scan.
// Depends on pts_pkg.
`default_nettype none

module pts_best #(
   parameter int THREAD_SLOTS  = 8,
   parameter int PRIORITY_BITS = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pts_pkg::scan_ctl_type    scan_ctl,
   input  wire logic [$clog2(THREAD_SLOTS)-1:0] cand_idx,
   input  wire logic [PRIORITY_BITS+pts_pkg::STATUS_W+pts_pkg::QUANT_W-1:0] cand_word,
   output logic                          found,
   output logic [$clog2(THREAD_SLOTS)-1:0] best_idx,
   output logic [PRIORITY_BITS+pts_pkg::STATUS_W+pts_pkg::QUANT_W-1:0] best_word
);

   localparam int AW = $clog2(THREAD_SLOTS);
   localparam int EW = PRIORITY_BITS + pts_pkg::STATUS_W + pts_pkg::QUANT_W;

   logic                      found_ff, found_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;
   logic [EW-1:0]             best_word_ff, best_word_in;
   logic [PRIORITY_BITS-1:0]  cand_prio, best_prio;
   logic [pts_pkg::STATUS_W-1:0] cand_status;
   logic                      take;

   assign cand_prio   = cand_word[EW-1 -: PRIORITY_BITS];
   assign cand_status = cand_word[pts_pkg::QUANT_W +: pts_pkg::STATUS_W];
   assign best_prio   = best_word_ff[EW-1 -: PRIORITY_BITS];
   assign take        = scan_ctl.sample && (cand_status == pts_pkg::THR_READY) &&
                        (!found_ff || (cand_prio > best_prio));

   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_word_in = best_word_ff;
      if (scan_ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in     = 1'b1;
         best_idx_in  = cand_idx;
         best_word_in = cand_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_word_ff <= best_word_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_word = best_word_ff;

endmodule

`default_nettype wire

/* src/pts_seq.sv */
// Command sequencer of the scheduler: decodes commands, drives the thread table and the
// compare unit, and holds the scheduler state and the result register. Depends on pts_pkg,
// the channel interfaces and the assertion macros.
`default_nettype none
`include "priority_thread_scheduler_macros.svh"

module pts_seq #(
   parameter int THREAD_SLOTS  = 8,
   parameter int PRIORITY_BITS = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pts_req_if.sink                       req,
   pts_rsp_if.source                     rsp,
   pts_csr_if.sink                       csr,
   output logic                          wr_en,
   output logic [$clog2(THREAD_SLOTS)-1:0] wr_addr,
   output logic [PRIORITY_BITS+pts_pkg::STATUS_W+pts_pkg::QUANT_W-1:0] wr_data,
   output logic [$clog2(THREAD_SLOTS)-1:0] rd_addr,
   input  wire logic [PRIORITY_BITS+pts_pkg::STATUS_W+pts_pkg::QUANT_W-1:0] rd_data,
   output pts_pkg::scan_ctl_type         scan_ctl,
   output logic [$clog2(THREAD_SLOTS)-1:0] cand_idx,
   input  wire logic                     found,
   input  wire logic [$clog2(THREAD_SLOTS)-1:0] best_idx,
   input  wire logic [PRIORITY_BITS+pts_pkg::STATUS_W+pts_pkg::QUANT_W-1:0] best_word
);

   localparam int AW = $clog2(THREAD_SLOTS);
   localparam int CW = $clog2(THREAD_SLOTS + 1);
   localparam int PB = PRIORITY_BITS;
   localparam int QW = pts_pkg::QUANT_W;
   localparam int SW = pts_pkg::STATUS_W;
   localparam int EW = PB + SW + QW;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_ISSUE   = 8'b0000_0010,
      S_EXEC    = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_PICK    = 8'b0001_0000,
      S_SW_CUR  = 8'b0010_0000,
      S_SW_BEST = 8'b0100_0000,
      S_FINISH  = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [1:0]      cmd_func_ff, cmd_func_in;
   logic [PB-1:0]   cmd_prio_ff, cmd_prio_in;
   logic [3:0]      cmd_tid_ff, cmd_tid_in;
   logic [1:0]      cmd_nst_ff, cmd_nst_in;
   logic [2:0]      cmd_irql_ff, cmd_irql_in;
   logic [CW-1:0]   used_ff, used_in;
   logic [CW-1:0]   cur_ff, cur_in;
   logic            resched_ff, resched_in;
   logic [QW-1:0]   qlen_ff, qlen_in;
   logic            switched_ff, switched_in;
   logic            preempt_ff, preempt_in;
   logic            full_ff, full_in;
   logic [CW-1:0]   scan_idx_ff, scan_idx_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pend_idx_ff, pend_idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [3:0]      rsp_id_ff, rsp_id_in;
   logic            rsp_sw_ff, rsp_sw_in;
   logic            rsp_rs_ff, rsp_rs_in;
   logic            rsp_pre_ff, rsp_pre_in;
   logic            rsp_full_ff, rsp_full_in;
   logic [3:0]      rsp_used_ff, rsp_used_in;

   logic [PB-1:0]   rd_prio;
   logic [SW-1:0]   rd_status;
   logic [QW-1:0]   rd_quant;
   logic [AW-1:0]   cur_addr, tid_addr;
   logic            tid_ok, table_full, below_dispatch, scan_issue, accept;
   logic [CW-1:0]   best_id;

   assign rd_prio        = rd_data[EW-1 -: PB];
   assign rd_status      = rd_data[QW +: SW];
   assign rd_quant       = rd_data[QW-1:0];
   assign cur_addr       = AW'(cur_ff - CW'(1));
   assign tid_addr       = AW'(cmd_tid_ff - 4'd1);
   assign tid_ok         = (cmd_tid_ff != 4'd0) && (int'(cmd_tid_ff) <= int'(used_ff)) &&
                           (int'(cmd_tid_ff) <= THREAD_SLOTS);
   assign table_full     = (used_ff == CW'(THREAD_SLOTS));
   assign below_dispatch = (cmd_irql_ff < pts_pkg::DISPATCH_LVL);
   assign scan_issue     = (scan_idx_ff < used_ff);
   assign best_id        = CW'(best_idx) + CW'(1);
   assign accept         = req.valid && req.ready;
   assign cand_idx       = pend_idx_ff;

   assign req.ready              = (state_ff == S_IDLE);
   assign csr.ready              = 1'b1;
   assign rsp.valid              = rsp_valid_ff;
   assign rsp.running_id         = rsp_id_ff;
   assign rsp.switched           = rsp_sw_ff;
   assign rsp.reschedule_pending = rsp_rs_ff;
   assign rsp.preempt_immediate  = rsp_pre_ff;
   assign rsp.table_full_error   = rsp_full_ff;
   assign rsp.threads_used       = rsp_used_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_func_in  = cmd_func_ff;
      cmd_prio_in  = cmd_prio_ff;
      cmd_tid_in   = cmd_tid_ff;
      cmd_nst_in   = cmd_nst_ff;
      cmd_irql_in  = cmd_irql_ff;
      used_in      = used_ff;
      cur_in       = cur_ff;
      resched_in   = resched_ff;
      qlen_in      = qlen_ff;
      switched_in  = switched_ff;
      preempt_in   = preempt_ff;
      full_in      = full_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_sw_in    = rsp_sw_ff;
      rsp_rs_in    = rsp_rs_ff;
      rsp_pre_in   = rsp_pre_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_used_in  = rsp_used_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_addr;
      wr_data      = rd_data;
      rd_addr      = cur_addr;
      scan_ctl     = '0;

      if (csr.valid) begin
         qlen_in = csr.quantum_length;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_func_in = req.func;
               cmd_prio_in = PB'(req.priority_req);
               cmd_tid_in  = req.thread_id;
               cmd_nst_in  = req.new_state;
               cmd_irql_in = req.irql_level;
               switched_in = 1'b0;
               preempt_in  = 1'b0;
               full_in     = 1'b0;
               state_in    = S_ISSUE;
            end
         end
         S_ISSUE: begin
            case (cmd_func_ff)
               pts_pkg::FN_CREATE: begin
                  if (table_full) begin
                     full_in  = 1'b1;
                     state_in = S_FINISH;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(used_ff);
                     wr_data  = {cmd_prio_ff, pts_pkg::THR_READY, qlen_ff};
                     used_in  = used_ff + CW'(1);
                     state_in = (cur_ff != '0) ? S_EXEC : S_FINISH;
                  end
               end
               pts_pkg::FN_TICK: begin
                  state_in = (cur_ff != '0) ? S_EXEC : S_FINISH;
               end
               pts_pkg::FN_SET: begin
                  rd_addr  = tid_addr;
                  state_in = tid_ok ? S_EXEC : S_FINISH;
               end
               default: begin
                  if (below_dispatch) begin
                     scan_ctl.clear = 1'b1;
                     scan_idx_in    = '0;
                     pend_in        = 1'b0;
                     state_in       = S_SCAN;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            endcase
         end
         S_EXEC: begin
            case (cmd_func_ff)
               pts_pkg::FN_CREATE: begin
                  if (cmd_prio_ff > rd_prio) begin
                     resched_in = 1'b1;
                     preempt_in = below_dispatch;
                  end
               end
               pts_pkg::FN_TICK: begin
                  wr_en = 1'b1;
                  if (rd_quant <= QW'(1)) begin
                     wr_data    = {rd_prio, rd_status, qlen_ff};
                     resched_in = 1'b1;
                  end else begin
                     wr_data = {rd_prio, rd_status, rd_quant - QW'(1)};
                  end
               end
               pts_pkg::FN_SET: begin
                  wr_en   = 1'b1;
                  wr_addr = tid_addr;
                  wr_data = {rd_prio, cmd_nst_ff, rd_quant};
               end
               default: begin
               end
            endcase
            state_in = S_FINISH;
         end
         S_SCAN: begin
            rd_addr         = AW'(scan_idx_ff);
            pend_in         = scan_issue;
            pend_idx_in     = AW'(scan_idx_ff);
            scan_ctl.sample = pend_ff;
            if (scan_issue) begin
               scan_idx_in = scan_idx_ff + CW'(1);
            end else if (!pend_ff) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            resched_in = 1'b0;
            if (found && (cur_ff != best_id)) begin
               switched_in = 1'b1;
               state_in    = S_SW_CUR;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SW_CUR: begin
            if ((cur_ff != '0) && (rd_status == pts_pkg::THR_RUNNING)) begin
               wr_en   = 1'b1;
               wr_data = {rd_prio, pts_pkg::THR_READY, rd_quant};
            end
            state_in = S_SW_BEST;
         end
         S_SW_BEST: begin
            wr_en    = 1'b1;
            wr_addr  = best_idx;
            wr_data  = {best_word[EW-1 -: PB], pts_pkg::THR_RUNNING, best_word[QW-1:0]};
            cur_in   = best_id;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = 4'(cur_ff);
               rsp_sw_in    = switched_ff;
               rsp_rs_in    = resched_ff;
               rsp_pre_in   = preempt_ff;
               rsp_full_in  = full_ff;
               rsp_used_in  = 4'(used_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cur_ff       <= '0;
         resched_ff   <= 1'b0;
         qlen_ff      <= pts_pkg::QUANTUM_RESET;
         switched_ff  <= 1'b0;
         preempt_ff   <= 1'b0;
         full_ff      <= 1'b0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cur_ff       <= cur_in;
         resched_ff   <= resched_in;
         qlen_ff      <= qlen_in;
         switched_ff  <= switched_in;
         preempt_ff   <= preempt_in;
         full_ff      <= full_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_func_ff <= cmd_func_in;
      cmd_prio_ff <= cmd_prio_in;
      cmd_tid_ff  <= cmd_tid_in;
      cmd_nst_ff  <= cmd_nst_in;
      cmd_irql_ff <= cmd_irql_in;
      pend_idx_ff <= pend_idx_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_pre_ff  <= rsp_pre_in;
      rsp_full_ff <= rsp_full_in;
      rsp_used_ff <= rsp_used_in;
   end

   `PTS_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= CW'(THREAD_SLOTS))
   `PTS_ASSERT_IMPL(a_cur_created, clock, reset, 1'b1, cur_ff <= used_ff)
   `PTS_ASSERT_NEXT(a_accept_issue, clock, reset, accept, state_ff == S_ISSUE)
   `PTS_ASSERT_IMPL(a_no_write_scan, clock, reset, wr_en, state_ff != S_IDLE && state_ff != S_SCAN)

endmodule

`default_nettype wire

/* src/priority_thread_scheduler.sv */
// Priority thread scheduler: top level joining the sequencer, compare unit and thread table.
// Depends on pts_pkg, the channel interfaces, pts_seq, pts_best and pts_table.
//
// One command word is taken at a time and answered by exactly one result word. Create, tick
// and set-state pass from acceptance through the issue state, and where needed the execute
// state, to the finish state; schedule reads the table through its one read port, and the scan
// visits one entry per cycle through the shared priority compare unit. Results wait in an
// output register, so the next command is accepted while the previous result is pending.
// The quantum length may be written at any time while no command is in flight.
`default_nettype none

module priority_thread_scheduler #(
   parameter int THREAD_SLOTS  = 8,
   parameter int PRIORITY_BITS = 5
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pts_req_if.sink     req_chan,
   pts_rsp_if.source   rsp_chan,
   pts_csr_if.sink     csr_chan
);

   localparam int AW = $clog2(THREAD_SLOTS);
   localparam int EW = PRIORITY_BITS + pts_pkg::STATUS_W + pts_pkg::QUANT_W;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr, cand_idx, best_idx;
   logic [EW-1:0]         wr_data, rd_data, best_word;
   logic                  found;
   pts_pkg::scan_ctl_type scan_ctl;

   pts_seq #(
      .THREAD_SLOTS  (THREAD_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr       (csr_chan),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .scan_ctl  (scan_ctl),
      .cand_idx  (cand_idx),
      .found     (found),
      .best_idx  (best_idx),
      .best_word (best_word)
   );

   pts_best #(
      .THREAD_SLOTS  (THREAD_SLOTS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .scan_ctl  (scan_ctl),
      .cand_idx  (cand_idx),
      .cand_word (rd_data),
      .found     (found),
      .best_idx  (best_idx),
      .best_word (best_word)
   );

   pts_table #(
      .DEPTH (THREAD_SLOTS),
      .WIDTH (EW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

`default_nettype wire
